### src/mfrg_pkg.sv
// ============================================================================
// mfrg_pkg: shared types and constants of the multichannel frame rate gate
// Holds the widths, command and register codes, the sequencer states and the
// status bundle of the shared serial divider.
// ============================================================================
`default_nettype none

package mfrg_pkg;

    localparam int CHANNELS  = 16;
    localparam int TIME_BITS = 48;
    localparam int CH_W      = $clog2(CHANNELS);

    localparam int PERIOD_W  = 20;
    localparam int DIVD_W    = 24;
    localparam int DIVS_W    = 10;
    localparam int TOKEN_W   = 21;
    localparam int RATE_W    = 8;
    localparam int ACT_W     = 5;
    localparam int REFILL_W  = TOKEN_W + RATE_W;
    localparam int SUM_W     = REFILL_W + 1;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);

    localparam logic [PERIOD_W-1:0] US_PER_S   = 20'd1000000;
    localparam logic [TOKEN_W-1:0]  ONE_TOKEN  = 21'd1000000;
    localparam logic [TOKEN_W-1:0]  TOKEN_CAP  = 21'd2000000;

    localparam logic [ACT_W-1:0]  ACT_RESET  = 5'd1;
    localparam logic [RATE_W-1:0] RATE_RESET = 8'd30;

    localparam logic [1:0] CMD_FRAME   = 2'd0;
    localparam logic [1:0] CMD_BACKOFF = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic REG_ACTIVE_CHANNELS = 1'b0;
    localparam logic REG_PREVIEW_RATE    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_PH_MUL,
        ST_PH_GO,
        ST_PH_WAIT,
        ST_JUDGE,
        ST_DECIDE,
        ST_ACCUM,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### src/multichannel_frame_rate_gate.sv
// ============================================================================
// multichannel_frame_rate_gate: per-channel frame gate with preview bucket
// Decides per frame event whether the frame is analysed and whether it goes
// to preview; handles backoff and channel clear events.
// ============================================================================
// A frame or backoff request runs the 24-step serial divider that derives
// the period from target_fps. The first frame on a channel without a due
// time runs the same divider a second time for the phase offset. Clear and
// unused requests skip the divider and go straight to the apply step. One
// request is in work at a time; in_ready is high only while the sequencer
// is idle, and a finished result waits in the output register while the
// next request is taken. Configuration writes are always accepted.
`default_nettype none

module multichannel_frame_rate_gate
    import mfrg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           cmd,
    input  wire logic [3:0]           channel,
    input  wire logic [TIME_BITS-1:0] now_us,
    input  wire logic [9:0]           target_fps,
    input  wire logic [3:0]           display_slot,
    input  wire logic                 preview_active,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      process,
    output logic                      preview_send,
    output logic                      preview_restart
);

    state_t state_reg;
    state_t state_next;

    logic [ACT_W-1:0]  active_channels_reg;
    logic [RATE_W-1:0] preview_rate_reg;

    logic [1:0]           cmd_reg;
    logic [3:0]           chan_reg;
    logic                 chan_ok_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [9:0]           fps_reg;
    logic [3:0]           slot_reg;
    logic                 active_reg;

    logic [CHANNELS-1:0]  due_valid_reg;
    logic [CHANNELS-1:0]  started_reg;
    logic [TOKEN_W-1:0]   token_level_reg [CHANNELS];
    logic [TIME_BITS-1:0] due_mem [CHANNELS];
    logic [TIME_BITS-1:0] last_mem [CHANNELS];
    logic [TIME_BITS-1:0] due_rd_reg;
    logic [TIME_BITS-1:0] last_rd_reg;

    logic [PERIOD_W-1:0]  period_reg;
    logic [DIVD_W-1:0]    prod_reg;
    logic [TIME_BITS-1:0] due_work_reg;
    logic [TIME_BITS:0]   due_p1_reg;
    logic [TIME_BITS:0]   due_p2_reg;
    logic [TOKEN_W-1:0]   elapsed_reg;
    logic [TIME_BITS-1:0] due_new_reg;
    logic                 hit_reg;
    logic [REFILL_W-1:0]  refill_reg;
    logic [TOKEN_W-1:0]   tok_sum_reg;

    logic                 out_valid_reg;
    logic                 process_reg;
    logic                 preview_send_reg;
    logic                 preview_restart_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 apply_fire;
    logic [CH_W-1:0]      chan_idx;
    logic                 div_start;
    logic [DIVD_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]    div_divisor;
    logic [DIVD_W-1:0]    div_quo;
    div_stat_t            div_stat;
    logic [9:0]           fps_div;
    logic [ACT_W-1:0]     act_div;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] now_half;
    logic                 due_hit;
    logic                 due_late;
    logic [SUM_W-1:0]     tok_add;
    logic                 tok_hit;
    logic [TOKEN_W-1:0]   tok_cur;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign apply_fire = (state_reg == ST_APPLY) && out_free;
    assign chan_idx   = chan_reg[CH_W-1:0];
    assign tok_cur    = token_level_reg[chan_idx];

    assign fps_div  = (fps_reg == '0) ? 10'd1 : fps_reg;
    assign act_div  = (active_channels_reg == '0) ? ACT_RESET : active_channels_reg;
    assign div_dividend = (state_reg == ST_PH_GO) ? prod_reg : DIVD_W'(US_PER_S);
    assign div_divisor  = (state_reg == ST_PH_GO) ? DIVS_W'(act_div) : DIVS_W'(fps_div);

    assign diff     = now_reg - last_rd_reg;
    assign now_half = now_reg + TIME_BITS'(period_reg >> 1);
    assign due_hit  = now_reg >= due_work_reg;
    assign due_late = {1'b0, now_reg} > due_p2_reg;
    assign tok_add  = SUM_W'(tok_cur) + SUM_W'(refill_reg);
    assign tok_hit  = tok_sum_reg >= ONE_TOKEN;

    mfrg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((int'(channel) < CHANNELS) &&
                        (cmd == CMD_FRAME || cmd == CMD_BACKOFF))
                    begin
                        state_next = ST_PER_GO;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_PER_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_PER_WAIT;
            end
            ST_PER_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (cmd_reg == CMD_FRAME && !due_valid_reg[chan_idx])
                    begin
                        state_next = ST_PH_MUL;
                    end
                    else
                    begin
                        state_next = ST_JUDGE;
                    end
                end
            end
            ST_PH_MUL:
            begin
                state_next = ST_PH_GO;
            end
            ST_PH_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_PH_WAIT;
            end
            ST_PH_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_channels_reg <= ACT_RESET;
            preview_rate_reg    <= RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ACTIVE_CHANNELS: active_channels_reg <= cfg_data[ACT_W-1:0];
                REG_PREVIEW_RATE:    preview_rate_reg    <= cfg_data[RATE_W-1:0];
                default:             ;
            endcase
        end
    end

    // hold request payload and run the datapath steps
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg     <= cmd;
            chan_reg    <= channel;
            chan_ok_reg <= int'(channel) < CHANNELS;
            now_reg     <= now_us;
            fps_reg     <= target_fps;
            slot_reg    <= display_slot;
            active_reg  <= preview_active;
        end

        if (state_reg == ST_PER_WAIT && div_stat.done)
        begin
            period_reg   <= div_quo[PERIOD_W-1:0];
            due_work_reg <= due_rd_reg;
        end

        if (state_reg == ST_PH_MUL)
        begin
            prod_reg <= DIVD_W'(period_reg) * DIVD_W'(slot_reg);
        end

        if (state_reg == ST_PH_WAIT && div_stat.done)
        begin
            due_work_reg <= now_reg + TIME_BITS'(div_quo);
        end

        if (state_reg == ST_JUDGE)
        begin
            due_p1_reg <= {1'b0, due_work_reg} + (TIME_BITS + 1)'(period_reg);
            due_p2_reg <= {1'b0, due_work_reg} + (TIME_BITS + 1)'({period_reg, 1'b0});
            if (now_reg < last_rd_reg)
            begin
                elapsed_reg <= '0;
            end
            else if (diff >= TIME_BITS'(TOKEN_CAP))
            begin
                elapsed_reg <= TOKEN_CAP;
            end
            else
            begin
                elapsed_reg <= diff[TOKEN_W-1:0];
            end
        end

        if (state_reg == ST_DECIDE)
        begin
            hit_reg    <= due_hit;
            refill_reg <= REFILL_W'(elapsed_reg) * REFILL_W'(preview_rate_reg);
            if (cmd_reg == CMD_BACKOFF)
            begin
                due_new_reg <= now_half;
            end
            else if (!due_hit)
            begin
                due_new_reg <= due_work_reg;
            end
            else if (due_late)
            begin
                due_new_reg <= now_half;
            end
            else
            begin
                due_new_reg <= due_p1_reg[TIME_BITS-1:0];
            end
        end

        if (state_reg == ST_ACCUM)
        begin
            tok_sum_reg <= (tok_add > SUM_W'(TOKEN_CAP)) ? TOKEN_CAP
                                                         : tok_add[TOKEN_W-1:0];
        end

        if (apply_fire)
        begin
            process_reg         <= chan_ok_reg && cmd_reg == CMD_FRAME && hit_reg;
            preview_send_reg    <= chan_ok_reg && cmd_reg == CMD_FRAME && active_reg &&
                                   (!started_reg[chan_idx] || tok_hit);
            preview_restart_reg <= chan_ok_reg && cmd_reg == CMD_FRAME && active_reg &&
                                   !started_reg[chan_idx];
        end
    end

    // per-channel time stores
    always_ff @(posedge clk)
    begin
        due_rd_reg  <= due_mem[chan_idx];
        last_rd_reg <= last_mem[chan_idx];
        if (apply_fire && chan_ok_reg)
        begin
            if (cmd_reg == CMD_FRAME || cmd_reg == CMD_BACKOFF)
            begin
                due_mem[chan_idx] <= due_new_reg;
            end
            if (cmd_reg == CMD_FRAME && active_reg)
            begin
                last_mem[chan_idx] <= now_reg;
            end
        end
    end

    // per-channel flags and token bucket
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_valid_reg <= '0;
            started_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                token_level_reg[i] <= ONE_TOKEN;
            end
        end
        else if (apply_fire && chan_ok_reg)
        begin
            case (cmd_reg)
                CMD_FRAME:
                begin
                    due_valid_reg[chan_idx] <= 1'b1;
                    if (!active_reg)
                    begin
                        started_reg[chan_idx]     <= 1'b0;
                        token_level_reg[chan_idx] <= ONE_TOKEN;
                    end
                    else if (!started_reg[chan_idx])
                    begin
                        started_reg[chan_idx]     <= 1'b1;
                        token_level_reg[chan_idx] <= '0;
                    end
                    else if (tok_hit)
                    begin
                        token_level_reg[chan_idx] <= tok_sum_reg - ONE_TOKEN;
                    end
                    else
                    begin
                        token_level_reg[chan_idx] <= tok_sum_reg;
                    end
                end
                CMD_BACKOFF:
                begin
                    due_valid_reg[chan_idx] <= 1'b1;
                end
                CMD_CLEAR:
                begin
                    due_valid_reg[chan_idx]   <= 1'b0;
                    started_reg[chan_idx]     <= 1'b0;
                    token_level_reg[chan_idx] <= ONE_TOKEN;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (apply_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign process         = process_reg;
    assign preview_send    = preview_send_reg;
    assign preview_restart = preview_restart_reg;

`ifndef NO_ASSERTIONS
    a_restart_sends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && preview_restart |-> preview_send)
        else $error("preview restart without preview frame");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_PER_WAIT || state_reg == ST_PH_WAIT))
        else $error("divider finished outside a wait state");

    a_token_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> token_level_reg[chan_idx] <= TOKEN_CAP)
        else $error("token level above cap");

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_APPLY))
        else $error("result raised outside apply step");
`endif

endmodule

`default_nettype wire

### src/mfrg_div.sv
// ============================================================================
// mfrg_div: shared serial divider
// Restoring division, one quotient bit per cycle. A start request loads the
// operands; done pulses for one cycle when the quotient is ready and held.
// ============================================================================
`default_nettype none

module mfrg_div
    import mfrg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0]      quotient,
    output div_stat_t              stat
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] count_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] divisor_reg;

    logic [DIVS_W:0]   rem_shift;
    logic              step_ge;
    logic [DIVS_W:0]   rem_sub;
    logic              last_step;

    assign rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign step_ge   = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign last_step = busy_reg && (count_reg == DCNT_W'(DIVD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], step_ge};
            rem_reg <= step_ge ? rem_sub[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
